// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL that carries checks.
// Needs no package; NO_ASSERTIONS strips every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/cst_pkg.sv =====
// Types and constants of the cuckoo set-summary table.
// Used by cst_ctrl, cst_dp and the top level.
`default_nettype none
package cst_pkg;
  localparam int BUCKETS    = 128;
  localparam int BKT_W      = 7;
  localparam int SLOTS      = 8;
  localparam int SLOT_W     = 3;
  localparam int SIG_W      = 16;
  localparam int SET_W      = 16;
  localparam int ENTRY_W    = SIG_W + SET_W;
  localparam int ROW_W      = SLOTS * ENTRY_W;
  localparam int PUSH_LIMIT = 8;
  localparam int REC_W      = 3;
  localparam int CFG_W      = 4;
  localparam logic [CFG_W-1:0] PUSH_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_MISS      = 3'd0,
    ST_HIT       = 3'd1,
    ST_DIRECT    = 3'd2,
    ST_DISPLACED = 3'd3,
    ST_BAD_ID    = 3'd4,
    ST_NO_SPACE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    RD_PRIM  = 3'd0,
    RD_SEC   = 3'd1,
    RD_CUR   = 3'd2,
    RD_PROBE = 3'd3,
    RD_SRC   = 3'd4
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_NEW   = 2'd1,
    WR_MOVE  = 2'd2,
    WR_PLACE = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    clr;
    logic    in_load;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    res_cap;
    logic    walk_init;
    logic    row_lat;
    logic    i_clr;
    logic    i_inc;
    logic    found;
    logic    pick;
    logic    mv_src;
    logic    mv_step;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_add;
    logic bad_id;
    logic hit;
    logic has_empty;
    logic lim_zero;
    logic probe_last;
    logic pick_none;
    logic walk_last;
    logic mv_last;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/cst_dp.sv =====
// Datapath: bucket row memory, item registers, walk records and result data.
// Depends on cst_pkg; sequenced by cst_ctrl.
`default_nettype none
module cst_dp import cst_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             op,
  input  wire logic [SIG_W-1:0] signature,
  input  wire logic [BKT_W-1:0] primary_bucket,
  input  wire logic [SET_W-1:0] new_set_id,
  output logic      [SET_W-1:0] matched_set
);
  logic [ROW_W-1:0] mem [BUCKETS];
  logic [ROW_W-1:0] rd_data;
  logic [BKT_W-1:0] rd_bkt;
  logic [BKT_W-1:0] rd_addr;
  logic [BKT_W-1:0] clr_cnt;
  logic [CFG_W-1:0] max_pushes;

  logic             op_q;
  logic [SIG_W-1:0] sig_q;
  logic [BKT_W-1:0] prim_q;
  logic [SET_W-1:0] set_q;
  logic [SET_W-1:0] res_set;

  logic [SIG_W-1:0]  row_sig [SLOTS];
  logic [BKT_W-1:0]  cur;
  logic [SLOT_W-1:0] probe;
  logic [REC_W-1:0]  push_idx;
  logic [REC_W-1:0]  mv_idx;
  logic [BKT_W-1:0]  rec_bkt  [PUSH_LIMIT];
  logic [SLOT_W-1:0] rec_slot [PUSH_LIMIT];
  logic [BKT_W-1:0]  dst_bkt;
  logic [SLOT_W-1:0] dst_slot;
  logic [SLOT_W-1:0] src_slot;

  logic [BKT_W-1:0]  sec;
  logic [CFG_W-1:0]  limit;
  logic              hit;
  logic [SET_W-1:0]  hit_set;
  logic              has_empty;
  logic [SLOT_W-1:0] empty_slot;
  logic              pick_none;
  logic [SLOT_W-1:0] pick_slot;
  logic              wr_en;
  logic [BKT_W-1:0]  wr_bkt;
  logic [SLOT_W-1:0] wr_lane;
  logic [ENTRY_W-1:0] wr_entry;

  assign sec   = prim_q ^ sig_q[BKT_W-1:0];
  assign limit = (max_pushes > CFG_W'(PUSH_LIMIT)) ? CFG_W'(PUSH_LIMIT) : max_pushes;

  // match and first empty slot over the row just read
  always_comb begin
    hit        = 1'b0;
    hit_set    = '0;
    has_empty  = 1'b0;
    empty_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (rd_data[s*ENTRY_W+SIG_W +: SET_W] != '0 &&
          rd_data[s*ENTRY_W +: SIG_W] == sig_q) begin
        hit     = 1'b1;
        hit_set = rd_data[s*ENTRY_W+SIG_W +: SET_W];
      end
      if (rd_data[s*ENTRY_W+SIG_W +: SET_W] == '0) begin
        has_empty  = 1'b1;
        empty_slot = SLOT_W'(s);
      end
    end
  end

  // first slot of the current bucket not recorded earlier in this walk
  always_comb begin
    logic used;
    pick_none = 1'b1;
    pick_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      used = 1'b0;
      for (int r = 0; r < PUSH_LIMIT; r++) begin
        if (REC_W'(r) < push_idx && rec_bkt[r] == cur && rec_slot[r] == SLOT_W'(s))
          used = 1'b1;
      end
      if (!used) begin
        pick_none = 1'b0;
        pick_slot = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PRIM:  rd_addr = prim_q;
      RD_SEC:   rd_addr = sec;
      RD_CUR:   rd_addr = cur;
      RD_PROBE: rd_addr = cur ^ row_sig[probe][BKT_W-1:0];
      RD_SRC:   rd_addr = rec_bkt[mv_idx];
      default:  rd_addr = prim_q;
    endcase
  end

  always_comb begin
    wr_en    = 1'b1;
    wr_bkt   = dst_bkt;
    wr_lane  = dst_slot;
    wr_entry = {set_q, sig_q};
    unique case (cmd.wr_sel)
      WR_NONE:  wr_en = 1'b0;
      WR_NEW: begin
        wr_bkt  = rd_bkt;
        wr_lane = empty_slot;
      end
      WR_MOVE:  wr_entry = rd_data[src_slot*ENTRY_W +: ENTRY_W];
      WR_PLACE: wr_entry = {set_q, sig_q};
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_cnt] <= '0;
    end else if (wr_en) begin
      mem[wr_bkt][wr_lane*ENTRY_W +: ENTRY_W] <= wr_entry;
    end
    rd_data <= mem[rd_addr];
    rd_bkt  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      max_pushes <= PUSH_RESET;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) max_pushes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q    <= op;
      sig_q   <= signature;
      prim_q  <= primary_bucket;
      set_q   <= new_set_id;
      res_set <= '0;
    end
    if (cmd.res_cap) res_set <= hit ? hit_set : '0;
    if (cmd.out_load) matched_set <= res_set;
    if (cmd.walk_init) begin
      cur      <= sig_q[0] ? prim_q : sec;
      push_idx <= '0;
    end
    if (cmd.row_lat) begin
      for (int s = 0; s < SLOTS; s++) row_sig[s] <= rd_data[s*ENTRY_W +: SIG_W];
    end
    if (cmd.i_clr) probe <= '0;
    if (cmd.i_inc) probe <= probe + 1'b1;
    if (cmd.found) begin
      rec_bkt[push_idx]  <= cur;
      rec_slot[push_idx] <= probe;
      dst_bkt            <= rd_bkt;
      dst_slot           <= empty_slot;
      mv_idx             <= push_idx;
    end
    if (cmd.pick) begin
      rec_bkt[push_idx]  <= cur;
      rec_slot[push_idx] <= pick_slot;
      cur                <= cur ^ row_sig[pick_slot][BKT_W-1:0];
      push_idx           <= push_idx + 1'b1;
    end
    if (cmd.mv_src) src_slot <= rec_slot[mv_idx];
    if (cmd.mv_step) begin
      dst_bkt  <= rd_bkt;
      dst_slot <= src_slot;
      mv_idx   <= mv_idx - 1'b1;
    end
  end

  always_comb begin
    stat.clr_last   = &clr_cnt;
    stat.is_add     = op_q;
    stat.bad_id     = (set_q == '0) || set_q[SET_W-1];
    stat.hit        = hit;
    stat.has_empty  = has_empty;
    stat.lim_zero   = (limit == '0);
    stat.probe_last = &probe;
    stat.pick_none  = pick_none;
    stat.walk_last  = ({1'b0, push_idx} + 1'b1) == limit;
    stat.mv_last    = (mv_idx == '0);
  end
endmodule
`default_nettype wire

// ===== rtl/core/cst_ctrl.sv =====
// Controller: sequences clearing, lookup, add and the displacement walk.
// Depends on cst_pkg; drives cst_dp by command struct.
`default_nettype none
module cst_ctrl import cst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic [2:0]    status
);
  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_RD_P  = 14'b00000000000100,
    S_CHK_P = 14'b00000000001000,
    S_CHK_S = 14'b00000000010000,
    S_W_RD  = 14'b00000000100000,
    S_W_LAT = 14'b00000001000000,
    S_W_ISS = 14'b00000010000000,
    S_W_PRB = 14'b00000100000000,
    S_W_PCK = 14'b00001000000000,
    S_M_RD  = 14'b00010000000000,
    S_M_WR  = 14'b00100000000000,
    S_PLACE = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t  state, state_next;
  status_t st_pend, st_pend_next;

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_PRIM;
    cmd.wr_sel   = WR_NONE;
    state_next   = state;
    st_pend_next = st_pend;
    in_ready     = 1'b0;
    unique case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_RD_P;
        end
      end
      S_RD_P: state_next = S_CHK_P;
      S_CHK_P: begin
        cmd.rd_sel = RD_SEC;
        if (!stat.is_add) begin
          if (stat.hit) begin
            cmd.res_cap  = 1'b1;
            st_pend_next = ST_HIT;
            state_next   = S_FIN;
          end else begin
            state_next = S_CHK_S;
          end
        end else if (stat.bad_id) begin
          st_pend_next = ST_BAD_ID;
          state_next   = S_FIN;
        end else if (stat.has_empty) begin
          cmd.wr_sel   = WR_NEW;
          st_pend_next = ST_DIRECT;
          state_next   = S_FIN;
        end else begin
          state_next = S_CHK_S;
        end
      end
      S_CHK_S: begin
        state_next = S_FIN;
        if (!stat.is_add) begin
          cmd.res_cap  = 1'b1;
          st_pend_next = stat.hit ? ST_HIT : ST_MISS;
        end else if (stat.has_empty) begin
          cmd.wr_sel   = WR_NEW;
          st_pend_next = ST_DIRECT;
        end else if (stat.lim_zero) begin
          st_pend_next = ST_NO_SPACE;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_W_RD;
        end
      end
      S_W_RD: begin
        cmd.rd_sel = RD_CUR;
        state_next = S_W_LAT;
      end
      S_W_LAT: begin
        cmd.row_lat = 1'b1;
        cmd.i_clr   = 1'b1;
        state_next  = S_W_ISS;
      end
      S_W_ISS: begin
        cmd.rd_sel = RD_PROBE;
        state_next = S_W_PRB;
      end
      S_W_PRB: begin
        if (stat.has_empty) begin
          cmd.found  = 1'b1;
          state_next = S_M_RD;
        end else if (stat.probe_last) begin
          state_next = S_W_PCK;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_W_ISS;
        end
      end
      S_W_PCK: begin
        if (stat.pick_none) begin
          st_pend_next = ST_NO_SPACE;
          state_next   = S_FIN;
        end else begin
          cmd.pick = 1'b1;
          if (stat.walk_last) begin
            st_pend_next = ST_NO_SPACE;
            state_next   = S_FIN;
          end else begin
            state_next = S_W_RD;
          end
        end
      end
      S_M_RD: begin
        cmd.rd_sel = RD_SRC;
        cmd.mv_src = 1'b1;
        state_next = S_M_WR;
      end
      S_M_WR: begin
        cmd.wr_sel  = WR_MOVE;
        cmd.mv_step = 1'b1;
        state_next  = stat.mv_last ? S_PLACE : S_M_RD;
      end
      S_PLACE: begin
        cmd.wr_sel   = WR_PLACE;
        st_pend_next = ST_DISPLACED;
        state_next   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    st_pend <= st_pend_next;
    if (cmd.out_load) status <= st_pend;
  end
endmodule
`default_nettype wire

// ===== rtl/core/cuckoo_set_summary_table.sv =====
// Top level of the cuckoo set-summary table: controller plus datapath.
// Depends on cst_pkg, cst_ctrl, cst_dp and assert_macros.svh.
//
//  channel   handshake            beat contents
//  in        in_valid/in_ready    op, signature, primary_bucket, new_set_id
//  out       out_valid/out_ready  status, matched_set
//  cfg       cfg_we               cfg_data (max_pushes)
//
// One item at a time. Lookup and direct add make one row read per bucket.
// A walk step reads the current bucket, then the alternate bucket of each slot in turn;
// a chain move reads and writes once per entry.
// After reset a clearing pass over all 128 buckets runs before in_ready rises.
// A pending result holds the block in its final state until out_ready.
`default_nettype none
`include "assert_macros.svh"
module cuckoo_set_summary_table import cst_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             op,
  input  wire logic [SIG_W-1:0] signature,
  input  wire logic [BKT_W-1:0] primary_bucket,
  input  wire logic [SET_W-1:0] new_set_id,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            status,
  output logic [SET_W-1:0]      matched_set,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .cmd       (cmd),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status)
  );

  cst_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .op             (op),
    .signature      (signature),
    .primary_bucket (primary_bucket),
    .new_set_id     (new_set_id),
    .matched_set    (matched_set)
  );

  `ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLIES(a_set_only_on_hit, clk, rst, out_valid && status != ST_HIT, matched_set == '0)
  `ASSERT_IMPLIES(a_load_when_free, clk, rst, cmd.out_load, !out_valid || out_ready)
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for cuckoo_set_summary_table: a software copy of the table predicts each result.
// Depends on cst_pkg and the RTL of the table; reads no files.
`default_nettype none
module testbench;
  import cst_pkg::*;

  logic             clk = 0;
  logic             rst = 1;
  logic             in_valid = 0;
  logic             in_ready;
  logic             op = 0;
  logic [SIG_W-1:0] signature = '0;
  logic [BKT_W-1:0] primary_bucket = '0;
  logic [SET_W-1:0] new_set_id = '0;
  logic             out_valid;
  logic             out_ready = 0;
  logic [2:0]       status;
  logic [SET_W-1:0] matched_set;
  logic             cfg_we = 0;
  logic [CFG_W-1:0] cfg_data = '0;

  cuckoo_set_summary_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .signature(signature), .primary_bucket(primary_bucket),
    .new_set_id(new_set_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .matched_set(matched_set),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the table
  logic [SIG_W-1:0] shadow_sig [BUCKETS*SLOTS];
  logic [SET_W-1:0] shadow_set [BUCKETS*SLOTS];
  bit               walk_mark  [BUCKETS*SLOTS];
  int               push_limit;

  typedef struct packed {
    status_t          st;
    logic [SET_W-1:0] set;
  } verdict_t;

  verdict_t         pending_verdicts[$];
  int               errors;
  bit               hold_go = 0;
  bit               holding = 0;
  int               burst_left;
  int               gap_left;
  logic [SIG_W-1:0] recent_sigs[$];

  function automatic int first_free(input int b);
    for (int s = 0; s < SLOTS; s++)
      if (shadow_set[b*SLOTS+s] == 0) return s;
    return -1;
  endfunction

  function automatic status_t walk_insert(input int start, input logic [SIG_W-1:0] sg,
                                          input logic [SET_W-1:0] id);
    int rb [PUSH_LIMIT+1];
    int rs [PUSH_LIMIT+1];
    int lim, cur, p, nb, j, k, dst, src, i;
    bit found;
    lim = (push_limit > PUSH_LIMIT) ? PUSH_LIMIT : push_limit;
    cur = start;
    found = 0;
    for (k = 0; k < BUCKETS*SLOTS; k++) walk_mark[k] = 0;
    for (p = 0; p < lim; p++) begin
      for (i = 0; i < SLOTS; i++) begin
        nb = (cur ^ shadow_sig[cur*SLOTS+i]) % BUCKETS;
        j = first_free(nb);
        if (j >= 0) begin
          rb[p] = cur; rs[p] = i; rb[p+1] = nb; rs[p+1] = j;
          found = 1;
          break;
        end
      end
      if (found) begin
        p++;
        break;
      end
      for (i = 0; i < SLOTS; i++) begin
        k = cur*SLOTS + i;
        if (!walk_mark[k]) begin
          rb[p] = cur; rs[p] = i; walk_mark[k] = 1;
          cur = (cur ^ shadow_sig[k]) % BUCKETS;
          break;
        end
      end
      if (i == SLOTS) return ST_NO_SPACE;
    end
    if (!found) return ST_NO_SPACE;
    for (; p > 0; p--) begin
      dst = rb[p]*SLOTS + rs[p];
      src = rb[p-1]*SLOTS + rs[p-1];
      shadow_sig[dst] = shadow_sig[src];
      shadow_set[dst] = shadow_set[src];
    end
    k = rb[0]*SLOTS + rs[0];
    shadow_sig[k] = sg;
    shadow_set[k] = id;
    return ST_DISPLACED;
  endfunction

  function automatic verdict_t predict_access(input logic is_add, input logic [SIG_W-1:0] sg,
                                              input logic [BKT_W-1:0] pb,
                                              input logic [SET_W-1:0] id);
    verdict_t v;
    int sb, s, b, k;
    v.st = ST_MISS;
    v.set = '0;
    sb = (pb ^ sg) % BUCKETS;
    if (!is_add) begin
      for (int pass = 0; pass < 2 && v.st == ST_MISS; pass++) begin
        b = pass ? sb : pb;
        for (s = 0; s < SLOTS; s++) begin
          k = b*SLOTS + s;
          if (shadow_set[k] != 0 && shadow_sig[k] == sg) begin
            v.st = ST_HIT;
            v.set = shadow_set[k];
            break;
          end
        end
      end
    end else if (id == 0 || id[SET_W-1]) begin
      v.st = ST_BAD_ID;
    end else begin
      b = pb;
      s = first_free(pb);
      if (s < 0) begin
        b = sb;
        s = first_free(sb);
      end
      if (s >= 0) begin
        shadow_sig[b*SLOTS+s] = sg;
        shadow_set[b*SLOTS+s] = id;
        v.st = ST_DIRECT;
      end else begin
        v.st = walk_insert(sg[0] ? pb : sb, sg, id);
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // one beat on the input channel; bursts and gaps come from the counters
  task automatic send_item(input logic is_add, input logic [SIG_W-1:0] sg,
                           input logic [BKT_W-1:0] pb, input logic [SET_W-1:0] id);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    in_valid <= 1;
    op <= is_add;
    signature <= sg;
    primary_bucket <= pb;
    new_set_id <= id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts.push_back(predict_access(is_add, sg, pb, id));
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left > 0) in_valid <= 0;
  endtask

  // block is busy after each beat it accepts, so dropping valid at the following edge is safe
  task automatic drain();
    @(posedge clk);
    in_valid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_push_limit(input int value);
    drain();
    cfg_we <= 1;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 0;
    push_limit = value;
  endtask

  // long receiver hold, counted here
  initial begin
    wait (hold_go);
    holding = 1;
    repeat (400) @(posedge clk);
    holding = 0;
  end

  // receiver: stall pattern plus an optional long hold
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (holding) out_ready <= 0;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result status", status, 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (status != want.st) report_mismatch("status", status, want.st);
        if (matched_set != want.set) report_mismatch("matched_set", matched_set, want.set);
      end
    end
  end

  function automatic logic [SET_W-1:0] good_id();
    return SET_W'($urandom_range(1, 16'h7fff));
  endfunction

  task automatic test_directed();
    send_item(1'b0, 16'h0000, 7'd0, 16'h0000);    // lookup in empty table
    send_item(1'b1, 16'h1234, 7'd5, 16'h0000);    // zero id rejected
    send_item(1'b1, 16'h1234, 7'd5, 16'h8000);    // top bit rejected
    send_item(1'b1, 16'hffff, 7'd127, 16'h7fff);
    send_item(1'b0, 16'hffff, 7'd127, 16'hffff);  // hit at extremes
    send_item(1'b1, 16'h0001, 7'd0, 16'h0001);
    send_item(1'b0, 16'h0001, 7'd1, 16'h0000);    // hit via secondary bucket
    send_item(1'b1, 16'h0002, 7'd3, 16'h0002);
    send_item(1'b1, 16'h0002, 7'd3, 16'h0003);    // duplicate signature
    send_item(1'b0, 16'h0002, 7'd3, 16'h5555);
    send_item(1'b0, 16'haaaa, 7'h55, 16'haaaa);   // miss
  endtask

  // fill one aligned group of four buckets until the walk kicks in and runs out
  task automatic test_crowded_pair(input int rounds);
    logic [BKT_W-1:0] pb;
    logic [SIG_W-1:0] sg;
    pb = BKT_W'($urandom_range(0, BUCKETS-1));
    for (int n = 0; n < rounds; n++) begin
      sg = {9'($urandom_range(0, 511)), 7'd0} | 16'($urandom_range(0, 3));
      send_item(1'b1, sg, pb ^ 7'($urandom_range(0, 3)), good_id());
    end
  endtask

  task automatic test_random(input int count);
    logic [SIG_W-1:0] sg;
    for (int n = 0; n < count; n++) begin
      if (recent_sigs.size() != 0 && $urandom_range(0, 2) == 0)
        sg = recent_sigs[$urandom_range(0, recent_sigs.size()-1)];
      else sg = SIG_W'($urandom);
      if ($urandom_range(0, 1)) begin
        recent_sigs.push_back(sg);
        if (recent_sigs.size() > 64) void'(recent_sigs.pop_front());
      end
      case ($urandom_range(0, 9))
        0: send_item(1'b1, sg, BKT_W'($urandom), SET_W'($urandom));
        1, 2, 3, 4, 5: send_item(1'b1, sg, 7'($urandom_range(0, 15)), good_id());
        default: send_item(1'b0, sg, 7'($urandom_range(0, 15)), SET_W'($urandom));
      endcase
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_go = 1;
    test_random(20);
  endtask

  initial begin
    errors = 0;
    burst_left = 0;
    gap_left = 0;
    push_limit = PUSH_RESET;
    foreach (shadow_sig[k]) begin
      shadow_sig[k] = '0;
      shadow_set[k] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 0;
    test_directed();
    test_crowded_pair(60);
    write_push_limit(1);
    test_crowded_pair(30);
    test_random(300);
    write_push_limit(0);
    test_crowded_pair(10);
    write_push_limit(15);
    test_random(300);
    write_push_limit(4);
    test_backpressure();
    test_random(400);
    write_push_limit(8);
    test_random(400);
    drain();
    if (errors == 0) $display("cuckoo_set_summary_table: match");
    else $display("cuckoo_set_summary_table: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("cuckoo_set_summary_table: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
